>>> sv/lmdc_pkg.sv
package lmdc_pkg;

    localparam int MAX_LINES_DEF     = 1024;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
    localparam logic [14:0] ERR_SCALE    = 15'd23040;
    localparam logic [30:0] LEN_MAX      = 31'h7FFF_FFFF;
    localparam logic [44:0] DEV_MAX      = 45'h0FFF_FFFF_FFFF;

    localparam int LEN_W  = 22;
    localparam int ERR_W  = 14;
    localparam int TERM_W = LEN_W + ERR_W;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] z;
    } t_cell;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [TERM_W-1:0] term;
    } t_term;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;
            20: v = 32'h0000028C;  21: v = 32'h00000146;
            22: v = 32'h000000A3;  23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/lmdc_if.sv
interface seg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               last_segment;
    modport source (output valid, start_x, start_y, end_x, end_y, last_segment, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, last_segment, output ready);
endinterface

interface res_if;
    logic               valid;
    logic               ready;
    logic signed [44:0] residual;
    logic        [30:0] length_sum;
    modport source (output valid, residual, length_sum, input ready);
    modport sink   (input valid, residual, length_sum, output ready);
endinterface

>>> sv/line_manhattan_deviation_cost_unit.sv
// Channel  | Dir | Payload
// i_seg    | in  | start_x, start_y, end_x, end_y, last_segment
// o_res    | out | residual, length_sum (one beat per last segment)
// i_cfg_*  | in  | rotation_angle
// One beat per cycle while o_res does not stall the pipeline.
// The whole pipeline stalls while a result beat waits on o_res.ready.
// Synchronous active-low reset clears valid flags and the running sums.
module line_manhattan_deviation_cost_unit
    import lmdc_pkg::*;
#(
    parameter int MAX_LINES     = MAX_LINES_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    seg_if.sink         i_seg,
    res_if.source       o_res,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    logic        en;
    logic [15:0] r_rot;
    t_cell       chain [0:CORDIC_STAGES];
    t_cell       r_pre;
    t_term       r_t2;
    logic signed [16:0] dx, dy;
    logic signed [31:0] x0, y0;
    logic        [30:0] mag;
    logic        [61:0] len_prod;
    logic        [31:0] d;
    logic        [29:0] r, dev;
    logic        [44:0] err_prod;
    logic [LEN_W-1:0]   r_len1;
    logic [ERR_W-1:0]   r_err1;
    logic               r_v1, r_l1;

    logic        acc_valid;
    logic [44:0] acc_res;
    logic [30:0] acc_lsum;

    assign en          = !o_res.valid || o_res.ready;
    assign i_seg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else if (i_cfg_we) begin
            r_rot <= i_cfg_wdata;
        end
    end

    always_comb begin
        dx = 17'(i_seg.end_x) - 17'(i_seg.start_x);
        dy = 17'(i_seg.end_y) - 17'(i_seg.start_y);
        x0 = 32'(dx) <<< 12;
        y0 = 32'(dy) <<< 12;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (en) begin
            r_pre.valid <= i_seg.valid;
        end
        if (en) begin
            r_pre.last <= i_seg.last_segment;
            // left half-plane: turn by half a turn first
            if (x0 < 0) begin
                r_pre.x <= -x0;
                r_pre.y <= -y0;
                r_pre.z <= 32'h8000_0000;
            end else begin
                r_pre.x <= x0;
                r_pre.y <= y0;
                r_pre.z <= '0;
            end
        end
    end

    assign chain[0] = r_pre;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        lmdc_cell #(.SHIFT(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_d    (chain[g]),
            .o_d    (chain[g+1])
        );
    end

    always_comb begin
        mag      = (chain[CORDIC_STAGES].x > 0) ? chain[CORDIC_STAGES].x[30:0] : '0;
        len_prod = 62'(mag) * 62'(INV_GAIN_Q30) + (62'd1 << 37);
        d        = chain[CORDIC_STAGES].z - {r_rot, 16'd0};
        r        = d[29:0];
        dev      = (r <= 30'h2000_0000) ? r : 30'(31'h4000_0000 - 31'(r));
        err_prod = 45'(dev) * 45'(ERR_SCALE) + (45'd1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_t2.valid <= 1'b0;
        end else if (en) begin
            r_v1       <= chain[CORDIC_STAGES].valid;
            r_t2.valid <= r_v1;
        end
        if (en) begin
            r_l1      <= chain[CORDIC_STAGES].last;
            r_len1    <= len_prod[38 +: LEN_W];
            r_err1    <= err_prod[30 +: ERR_W];
            r_t2.last <= r_l1;
            r_t2.len  <= r_len1;
            r_t2.term <= TERM_W'(r_len1) * TERM_W'(r_err1);
        end
    end

    lmdc_acc #(.MAX_LINES(MAX_LINES)) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_d         (r_t2),
        .o_valid     (acc_valid),
        .o_residual  (acc_res),
        .o_length_sum(acc_lsum)
    );

    assign o_res.valid      = acc_valid;
    assign o_res.residual   = acc_res;
    assign o_res.length_sum = acc_lsum;
endmodule

>>> sv/lmdc_cell.sv
module lmdc_cell
    import lmdc_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_d,
    output t_cell o_d
);
    localparam logic [31:0] ANG = atan_turn(SHIFT);

    t_cell r_d, n_d;
    logic signed [31:0] xs, ys;

    always_comb begin
        xs  = i_d.x >>> SHIFT;
        ys  = i_d.y >>> SHIFT;
        n_d = i_d;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ANG;
        end else if (i_d.y < 0) begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
        if (i_en) begin
            r_d.last <= n_d.last;
            r_d.x    <= n_d.x;
            r_d.y    <= n_d.y;
            r_d.z    <= n_d.z;
        end
    end

    assign o_d = r_d;
endmodule

>>> sv/lmdc_acc.sv
module lmdc_acc
    import lmdc_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_term        i_d,
    output logic         o_valid,
    output logic [44:0]  o_residual,
    output logic [30:0]  o_length_sum
);
    localparam int CNT_W = $clog2(MAX_LINES + 1);

    logic [30:0]      r_len, n_len;
    logic [44:0]      r_dev, n_dev;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid;
    logic [44:0]      r_res;
    logic [30:0]      r_lsum;
    logic [31:0]      len_sum;
    logic [45:0]      dev_sum;
    logic [45:0]      res_full;

    always_comb begin
        n_len    = r_len;
        n_dev    = r_dev;
        n_cnt    = r_cnt;
        len_sum  = {1'b0, r_len} + 32'(i_d.len);
        dev_sum  = {1'b0, r_dev} + 46'(i_d.term);
        if (i_d.valid && (r_cnt < CNT_W'(MAX_LINES))) begin
            n_len = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[30:0];
            n_dev = (dev_sum > {1'b0, DEV_MAX}) ? DEV_MAX : dev_sum[44:0];
            n_cnt = r_cnt + 1'b1;
        end
        res_full = {7'd0, n_len, 8'd0} - {1'b0, n_dev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_dev   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_d.valid && i_d.last;
            if (i_d.valid && i_d.last) begin
                r_len <= '0;
                r_dev <= '0;
                r_cnt <= '0;
            end else begin
                r_len <= n_len;
                r_dev <= n_dev;
                r_cnt <= n_cnt;
            end
        end
        if (i_en) begin
            r_res  <= res_full[44:0];
            r_lsum <= n_len;
        end
    end

    assign o_valid      = r_valid;
    assign o_residual   = r_res;
    assign o_length_sum = r_lsum;
endmodule

>>> sv/lmdc_checker.sv
module lmdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [44:0] i_residual,
    input logic [30:0] i_length_sum
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_residual)
        && $stable(i_length_sum)) else $error("result beat dropped or changed");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("result valid after reset");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_length_sum != 31'h0 || i_residual == 45'h0)
        else $error("nonzero residual with zero length");
endmodule

bind line_manhattan_deviation_cost_unit lmdc_checker u_lmdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_residual  (o_res.residual),
    .i_length_sum(o_res.length_sum)
);
